// ===== rtl/snp_pkg.sv =====
// Shared types, constants and fixed-point helpers of the snap profile evaluator.
package snp_pkg;

    localparam int SEG_COUNT = 7;
    localparam int SEG_DEPTH = 16;
    localparam int PIPE_LAT  = SEG_COUNT * SEG_DEPTH + 1;

    localparam logic [2:0] REG_A_RAMP  = 3'd0;
    localparam logic [2:0] REG_A_HOLD  = 3'd1;
    localparam logic [2:0] REG_CRUISE  = 3'd2;
    localparam logic [2:0] REG_C_RAMP  = 3'd3;
    localparam logic [2:0] REG_C_HOLD  = 3'd4;
    localparam logic [2:0] REG_SNAP_A  = 3'd5;
    localparam logic [2:0] REG_SNAP_C  = 3'd6;

    // internal values are clamped to +-2^61
    typedef logic signed [62:0] val_t;
    localparam logic signed [63:0] LIMIT64 = 64'sh2000_0000_0000_0000;

    localparam logic [4:0]  DIV6_K    = 5'd6;
    localparam logic [4:0]  DIV24_K   = 5'd24;
    localparam logic [4:0]  DIV6_RND  = 5'd3;
    localparam logic [4:0]  DIV24_RND = 5'd12;
    localparam logic [21:0] RECIP6    = 22'((1 << 24) / 6);
    localparam logic [21:0] RECIP24   = 22'((1 << 24) / 24);

    typedef struct packed {
        logic        neg;
        logic [63:0] p00;
        logic [63:0] p01;
        logic [63:0] p10;
        logic [63:0] p11;
    } pp_t;

    typedef struct packed {
        logic flag;
        val_t val;
    } sat_t;

    typedef struct packed {
        logic        neg;
        logic [63:0] n;
        logic [63:0] q;
        logic [4:0]  r;
    } div_t;

    typedef struct packed {
        logic        valid;
        logic        neg;
        logic [30:0] t;
        logic [34:0] tmin;
        logic        found;
        val_t        x;
        val_t        v;
        val_t        a;
        val_t        j;
        logic        clip;
    } ctx_t;

    function automatic logic [61:0] mag_of(val_t v);
        val_t m;
        m = v[62] ? -v : v;
        return m[61:0];
    endfunction

    function automatic val_t with_sign(logic neg, logic [61:0] m);
        val_t s;
        s = $signed({1'b0, m});
        return neg ? -s : s;
    endfunction

    // first half of a Q46.16 product: four 32x32 partial products
    function automatic pp_t qmul_pp(val_t a, val_t b);
        pp_t         p;
        logic [61:0] ma;
        logic [61:0] mb;
        logic [31:0] a0;
        logic [31:0] a1;
        logic [31:0] b0;
        logic [31:0] b1;
        ma    = mag_of(a);
        mb    = mag_of(b);
        a0    = ma[31:0];
        a1    = {2'b00, ma[61:32]};
        b0    = mb[31:0];
        b1    = {2'b00, mb[61:32]};
        p.neg = a[62] ^ b[62];
        p.p00 = 64'(a0) * 64'(b0);
        p.p01 = 64'(a0) * 64'(b1);
        p.p10 = 64'(a1) * 64'(b0);
        p.p11 = 64'(a1) * 64'(b1);
        return p;
    endfunction

    // second half: sum, round half away from zero, drop 16 bits, clamp
    function automatic sat_t qmul_fin(pp_t p);
        sat_t         s;
        logic [127:0] full;
        logic [111:0] q;
        logic [61:0]  m;
        full = {p.p11, 64'd0} + {32'd0, p.p01, 32'd0} + {32'd0, p.p10, 32'd0}
             + {64'd0, p.p00};
        full = full + 128'h8000;
        q    = full[127:16];
        s.flag = |q[111:61];
        m    = s.flag ? {1'b1, 61'd0} : q[61:0];
        s.val = with_sign(p.neg, m);
        return s;
    endfunction

    function automatic sat_t sadd(val_t a, val_t b);
        sat_t              s;
        logic signed [63:0] sum;
        sum = 64'(a) + 64'(b);
        if (sum > LIMIT64)
        begin
            s.flag = 1'b1;
            s.val  = val_t'(LIMIT64);
        end
        else if (sum < -LIMIT64)
        begin
            s.flag = 1'b1;
            s.val  = val_t'(-LIMIT64);
        end
        else
        begin
            s.flag = 1'b0;
            s.val  = sum[62:0];
        end
        return s;
    endfunction

    function automatic val_t half(val_t v);
        logic [62:0] m;
        m = {1'b0, mag_of(v)} + 63'd1;
        return with_sign(v[62], m[62:1]);
    endfunction

    function automatic div_t div_init(val_t v, logic [4:0] rnd);
        div_t d;
        d.neg = v[62];
        d.n   = {2'b00, mag_of(v)} + 64'(rnd);
        d.q   = '0;
        d.r   = '0;
        return d;
    endfunction

    // one 16-bit digit of long division by a small constant
    function automatic div_t div_step(div_t d, logic [4:0] k, logic [21:0] recip);
        div_t        o;
        logic [20:0] dd;
        logic [42:0] prod;
        logic [20:0] qd;
        logic [20:0] rem;
        dd   = {d.r, d.n[63:48]};
        prod = 43'(dd) * 43'(recip);
        qd   = 21'(prod[42:24]);
        rem  = dd - 21'(qd * 21'(k));
        if (rem >= 21'(k))
        begin
            qd  = qd + 21'd1;
            rem = rem - 21'(k);
        end
        o.neg = d.neg;
        o.q   = {d.q[47:0], qd[15:0]};
        o.n   = {d.n[47:0], 16'd0};
        o.r   = rem[4:0];
        return o;
    endfunction

    function automatic val_t div_apply(div_t d);
        return with_sign(d.neg, d.q[61:0]);
    endfunction

endpackage

// ===== rtl/snp_segment.sv =====
// One profile segment: sixteen-stage pipelined Taylor advance of x, v, a, j.
module snp_segment
    import snp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctx_t        ctx_in,
    input  logic [30:0] dur,
    input  val_t        snap,
    output ctx_t        ctx_out
);

    typedef struct packed {
        ctx_t      c;
        val_t      h;
        val_t      h2;
        val_t      h3;
        val_t      h4;
        val_t      vh;
        val_t      ah;
        val_t      jh;
        val_t      sh;
        val_t      ah2;
        val_t      jh2;
        val_t      sh2;
        val_t      jh3;
        val_t      sh3;
        val_t      sh4;
        pp_t [4:0] pp;
        div_t [2:0] d;
    } work_t;

    work_t w_reg  [0:SEG_DEPTH-1];
    work_t w_next [0:SEG_DEPTH-1];
    work_t src    [0:SEG_DEPTH-1];

    always_comb
    begin
        work_t       w;
        sat_t        s0;
        sat_t        s1;
        sat_t        s2;
        sat_t        s3;
        sat_t        s4;
        logic [34:0] tmax;
        logic [34:0] tq;

        src[0] = '0;
        src[0].c = ctx_in;
        for (int k = 1; k < SEG_DEPTH; k++)
        begin
            src[k] = w_reg[k-1];
        end

        for (int k = 0; k < SEG_DEPTH; k++)
        begin
            w    = src[k];
            tmax = w.c.tmin + 35'(dur);
            tq   = {4'd0, w.c.t};
            unique case (k)
                0:
                begin
                    // pick this segment's step; zero once an earlier one held the time
                    if (w.c.found)
                    begin
                        w.h = '0;
                    end
                    else if (tq <= tmax)
                    begin
                        w.h       = with_sign(1'b0, 62'(tq - w.c.tmin));
                        w.c.found = 1'b1;
                    end
                    else
                    begin
                        w.h      = with_sign(1'b0, 62'(dur));
                        w.c.tmin = tmax;
                    end
                end
                1:
                begin
                    w.pp[0] = qmul_pp(w.h, w.h);
                    w.pp[1] = qmul_pp(w.c.v, w.h);
                    w.pp[2] = qmul_pp(w.c.a, w.h);
                    w.pp[3] = qmul_pp(w.c.j, w.h);
                    w.pp[4] = qmul_pp(snap, w.h);
                end
                2:
                begin
                    s0 = qmul_fin(w.pp[0]);
                    s1 = qmul_fin(w.pp[1]);
                    s2 = qmul_fin(w.pp[2]);
                    s3 = qmul_fin(w.pp[3]);
                    s4 = qmul_fin(w.pp[4]);
                    w.h2 = s0.val;
                    w.vh = s1.val;
                    w.ah = s2.val;
                    w.jh = s3.val;
                    w.sh = s4.val;
                    w.c.clip = w.c.clip | s0.flag | s1.flag | s2.flag | s3.flag | s4.flag;
                end
                3:
                begin
                    w.pp[0] = qmul_pp(w.h2, w.h);
                    w.pp[1] = qmul_pp(w.c.a, w.h2);
                    w.pp[2] = qmul_pp(w.c.j, w.h2);
                    w.pp[3] = qmul_pp(snap, w.h2);
                end
                4:
                begin
                    s0 = qmul_fin(w.pp[0]);
                    s1 = qmul_fin(w.pp[1]);
                    s2 = qmul_fin(w.pp[2]);
                    s3 = qmul_fin(w.pp[3]);
                    w.h3  = s0.val;
                    w.ah2 = s1.val;
                    w.jh2 = s2.val;
                    w.sh2 = s3.val;
                    w.c.clip = w.c.clip | s0.flag | s1.flag | s2.flag | s3.flag;
                end
                5:
                begin
                    w.ah2   = half(w.ah2);
                    w.jh2   = half(w.jh2);
                    w.sh2   = half(w.sh2);
                    w.pp[0] = qmul_pp(w.h3, w.h);
                    w.pp[1] = qmul_pp(w.c.j, w.h3);
                    w.pp[2] = qmul_pp(snap, w.h3);
                end
                6:
                begin
                    s0 = qmul_fin(w.pp[0]);
                    s1 = qmul_fin(w.pp[1]);
                    s2 = qmul_fin(w.pp[2]);
                    w.h4  = s0.val;
                    w.jh3 = s1.val;
                    w.sh3 = s2.val;
                    w.c.clip = w.c.clip | s0.flag | s1.flag | s2.flag;
                end
                7:
                begin
                    w.pp[0] = qmul_pp(snap, w.h4);
                    w.d[0]  = div_init(w.jh3, DIV6_RND);
                    w.d[1]  = div_init(w.sh3, DIV6_RND);
                end
                8:
                begin
                    s0 = qmul_fin(w.pp[0]);
                    w.sh4 = s0.val;
                    w.c.clip = w.c.clip | s0.flag;
                    w.d[0] = div_step(w.d[0], DIV6_K, RECIP6);
                    w.d[1] = div_step(w.d[1], DIV6_K, RECIP6);
                end
                9:
                begin
                    w.d[0] = div_step(w.d[0], DIV6_K, RECIP6);
                    w.d[1] = div_step(w.d[1], DIV6_K, RECIP6);
                    w.d[2] = div_init(w.sh4, DIV24_RND);
                end
                10, 11:
                begin
                    w.d[0] = div_step(w.d[0], DIV6_K, RECIP6);
                    w.d[1] = div_step(w.d[1], DIV6_K, RECIP6);
                    w.d[2] = div_step(w.d[2], DIV24_K, RECIP24);
                end
                12:
                begin
                    w.jh3  = div_apply(w.d[0]);
                    w.sh3  = div_apply(w.d[1]);
                    w.d[2] = div_step(w.d[2], DIV24_K, RECIP24);
                end
                13:
                begin
                    w.d[2] = div_step(w.d[2], DIV24_K, RECIP24);
                end
                14:
                begin
                    // first half of the clamped sums, kept in the model's order
                    w.sh4 = div_apply(w.d[2]);
                    s0 = sadd(w.c.x, w.vh);
                    s1 = sadd(s0.val, w.ah2);
                    w.c.x = s1.val;
                    w.c.clip = w.c.clip | s0.flag | s1.flag;
                    s0 = sadd(w.c.v, w.ah);
                    s1 = sadd(s0.val, w.jh2);
                    w.c.v = s1.val;
                    w.c.clip = w.c.clip | s0.flag | s1.flag;
                    s0 = sadd(w.c.a, w.jh);
                    s1 = sadd(s0.val, w.sh2);
                    w.c.a = s1.val;
                    w.c.clip = w.c.clip | s0.flag | s1.flag;
                    s0 = sadd(w.c.j, w.sh);
                    w.c.j = s0.val;
                    w.c.clip = w.c.clip | s0.flag;
                end
                15:
                begin
                    s0 = sadd(w.c.x, w.jh3);
                    s1 = sadd(s0.val, w.sh4);
                    w.c.x = s1.val;
                    s2 = sadd(w.c.v, w.sh3);
                    w.c.v = s2.val;
                    w.c.clip = w.c.clip | s0.flag | s1.flag | s2.flag;
                end
                default:
                begin
                end
            endcase
            w_next[k] = w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SEG_DEPTH; k++)
            begin
                w_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < SEG_DEPTH; k++)
            begin
                w_reg[k] <= w_next[k];
            end
        end
    end

    assign ctx_out = w_reg[SEG_DEPTH-1].c;

endmodule

// ===== rtl/snap_profile_evaluator_core.sv =====
// Top level of the snap-limited seven-segment motion profile evaluator.
// A request accepted at one clock edge passes through seven segment pipelines of
// 16 stages each, then the output clip stage, before its result strobe.
// Throughput: one request per cycle; busy is always low and the receiver cannot stall.
// The depth is set by the chain of dependent products h^2..h^4 and the digit-serial
// division by 24 inside each segment.
// Reset (rst_n low, asynchronous) clears all configuration to 0 and empties the pipe.
module snap_profile_evaluator_core
    import snp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] query_time,
    input  logic signed [47:0] start_pos,
    input  logic signed [31:0] start_vel,
    input  logic signed [31:0] start_accel,
    output logic               done,
    output logic signed [47:0] position,
    output logic signed [31:0] velocity,
    output logic               before_start,
    output logic               saturated,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam val_t POS_MAX = val_t'(64'sd140737488355327);
    localparam val_t POS_MIN = val_t'(-64'sd140737488355328);
    localparam val_t VEL_MAX = val_t'(64'sd2147483647);
    localparam val_t VEL_MIN = val_t'(-64'sd2147483648);

    // configuration registers
    logic [30:0]        a_ramp_reg, a_ramp_next;
    logic [30:0]        a_hold_reg, a_hold_next;
    logic [30:0]        cruise_reg, cruise_next;
    logic [30:0]        c_ramp_reg, c_ramp_next;
    logic [30:0]        c_hold_reg, c_hold_next;
    logic signed [31:0] snap_a_reg, snap_a_next;
    logic signed [31:0] snap_c_reg, snap_c_next;

    // result registers
    logic               done_reg, done_next;
    logic signed [47:0] position_reg, position_next;
    logic signed [31:0] velocity_reg, velocity_next;
    logic               before_reg, before_next;
    logic               sat_reg, sat_next;

    logic [30:0] seg_dur  [0:SEG_COUNT-1];
    val_t        seg_snap [0:SEG_COUNT-1];
    ctx_t        chain    [0:SEG_COUNT];
    ctx_t        last;
    val_t        snap_a_v;
    val_t        snap_c_v;

    // every request goes straight into the pipe
    assign busy = 1'b0;

    always_comb
    begin
        a_ramp_next = a_ramp_reg;
        a_hold_next = a_hold_reg;
        cruise_next = cruise_reg;
        c_ramp_next = c_ramp_reg;
        c_hold_next = c_hold_reg;
        snap_a_next = snap_a_reg;
        snap_c_next = snap_c_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_A_RAMP: a_ramp_next = cfg_data[30:0];
                REG_A_HOLD: a_hold_next = cfg_data[30:0];
                REG_CRUISE: cruise_next = cfg_data[30:0];
                REG_C_RAMP: c_ramp_next = cfg_data[30:0];
                REG_C_HOLD: c_hold_next = cfg_data[30:0];
                REG_SNAP_A: snap_a_next = $signed(cfg_data);
                REG_SNAP_C: snap_c_next = $signed(cfg_data);
                default:
                begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // segment order: A ramp up, A hold, A ramp down, cruise, C ramp up, C hold, C ramp down
    assign snap_a_v = val_t'(snap_a_reg);
    assign snap_c_v = val_t'(snap_c_reg);
    assign seg_dur  = '{a_ramp_reg, a_hold_reg, a_ramp_reg, cruise_reg,
                        c_ramp_reg, c_hold_reg, c_ramp_reg};
    assign seg_snap = '{snap_a_v, val_t'(0), -snap_a_v, val_t'(0),
                        snap_c_v, val_t'(0), -snap_c_v};

    // a negative time is marked found up front: every step is zero and x passes through
    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = start && !busy;
        chain[0].neg   = query_time[31];
        chain[0].t     = query_time[30:0];
        chain[0].tmin  = '0;
        chain[0].found = query_time[31];
        chain[0].x     = val_t'(start_pos);
        chain[0].v     = val_t'(start_vel);
        chain[0].a     = val_t'(start_accel);
        chain[0].j     = '0;
        chain[0].clip  = 1'b0;
    end

    for (genvar g = 0; g < SEG_COUNT; g++)
    begin : g_seg
        snp_segment u_seg (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctx_in  (chain[g]),
            .dur     (seg_dur[g]),
            .snap    (seg_snap[g]),
            .ctx_out (chain[g+1])
        );
    end

    assign last = chain[SEG_COUNT];

    // output stage: clip to field ranges, override for negative time
    always_comb
    begin
        done_next     = last.valid;
        position_next = last.x[47:0];
        velocity_next = last.v[31:0];
        before_next   = 1'b0;
        sat_next      = last.clip;
        if (last.neg)
        begin
            velocity_next = '0;
            before_next   = 1'b1;
            sat_next      = 1'b0;
        end
        else
        begin
            if (last.x > POS_MAX)
            begin
                position_next = POS_MAX[47:0];
                sat_next      = 1'b1;
            end
            else if (last.x < POS_MIN)
            begin
                position_next = POS_MIN[47:0];
                sat_next      = 1'b1;
            end
            if (last.v > VEL_MAX)
            begin
                velocity_next = VEL_MAX[31:0];
                sat_next      = 1'b1;
            end
            else if (last.v < VEL_MIN)
            begin
                velocity_next = VEL_MIN[31:0];
                sat_next      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ramp_reg <= '0;
            a_hold_reg <= '0;
            cruise_reg <= '0;
            c_ramp_reg <= '0;
            c_hold_reg <= '0;
            snap_a_reg <= '0;
            snap_c_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            a_ramp_reg <= a_ramp_next;
            a_hold_reg <= a_hold_next;
            cruise_reg <= cruise_next;
            c_ramp_reg <= c_ramp_next;
            c_hold_reg <= c_hold_next;
            snap_a_reg <= snap_a_next;
            snap_c_reg <= snap_c_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        position_reg <= position_next;
        velocity_reg <= velocity_next;
        before_reg   <= before_next;
        sat_reg      <= sat_next;
    end

    assign done         = done_reg;
    assign position     = position_reg;
    assign velocity     = velocity_reg;
    assign before_start = before_reg;
    assign saturated    = sat_reg;

    // each request gives exactly one strobe after the fixed pipe depth
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(PIPE_LAT) done)
        else $error("request did not produce a result at the pipe depth");

    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_LAT))
        else $error("result strobe without a matching request");

    a_before_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && before_start |-> velocity == 32'sd0 && !saturated)
        else $error("negative-time result carries velocity or clip flag");

endmodule
